FILE: rtl/rgc_pkg.sv
`default_nettype none

package rgc_pkg;

    localparam int MAP_DIM       = 64;
    localparam int MAP_BITS      = 6;
    localparam int CELLS         = MAP_DIM * MAP_DIM;
    localparam int ADDR_BITS     = 2 * MAP_BITS;
    localparam int SCREEN_WIDTH  = 1024;
    localparam int SW_LOG2       = 10;
    localparam int SCREEN_HEIGHT = 768;
    localparam int FRAC_BITS     = 16;
    localparam int ONE           = 1 << FRAC_BITS;

    localparam int DIV_W   = 33;
    localparam int DSR_W   = 47;
    localparam int DELTA_W = 36;
    localparam int SIDE_W  = 44;

    localparam logic [DELTA_W-1:0] DELTA_MAX  = '1;
    localparam logic [SIDE_W-1:0]  SIDE_MAX   = '1;
    localparam logic [DIV_W-1:0]   RECIP_NUM  = 33'h1_0000_0000;
    localparam logic [DIV_W-1:0]   HEIGHT_NUM = 33'(SCREEN_HEIGHT * 7 * ONE);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y = 3'd5;

    typedef struct packed {
        logic        mode;
        logic [11:0] screen_column;
        logic [5:0]  cell_row;
        logic [5:0]  cell_col;
        logic        cell_is_wall;
    } in_item_t;

    typedef struct packed {
        logic [11:0] column_echo;
        logic [23:0] wall_distance;
        logic        hit_side;
        logic [5:0]  hit_cell_x;
        logic [5:0]  hit_cell_y;
        logic [15:0] slice_height;
        logic [11:0] draw_start;
        logic [11:0] draw_end;
        logic        left_map;
    } out_item_t;

    typedef struct packed {
        logic [21:0]        pos_x;
        logic [21:0]        pos_y;
        logic signed [17:0] dir_x;
        logic signed [17:0] dir_y;
        logic signed [17:0] plane_x;
        logic signed [17:0] plane_y;
    } cfg_t;

    typedef struct packed {
        logic     valid;
        in_item_t item;
    } q_head_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef struct packed {
        logic             go;
        logic [DIV_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CAM_X,
        ST_CAM_Y,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_SX_LO,
        ST_SX_HI,
        ST_SY_LO,
        ST_SY_HI,
        ST_WALK,
        ST_CHECK,
        ST_DIST,
        ST_HDIV_GO,
        ST_HDIV_WAIT,
        ST_OUT
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/rgc_div.sv
`default_nettype none

module rgc_div
    import rgc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic             busy_reg;
    logic             done_reg;
    logic [5:0]       cnt_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [DIV_W-1:0] dvd_reg;
    logic [DIV_W-1:0] quot_reg;

    logic [DSR_W:0]   trial;
    logic             ge;
    logic [DSR_W:0]   rem_step;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DIV_W-1]};
        ge       = trial >= {1'b0, dsr_reg};
        rem_step = ge ? (trial - {1'b0, dsr_reg}) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.go)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            rem_reg <= '0;
            dsr_reg <= req.divisor;
            dvd_reg <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_step[DSR_W-1:0];
            dvd_reg  <= {dvd_reg[DIV_W-2:0], 1'b0};
            quot_reg <= {quot_reg[DIV_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire

FILE: rtl/rgc_front.sv
`default_nettype none

module rgc_front
    import rgc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire in_item_t     cmd,
    output logic              busy,
    input  wire back_status_t status,
    output q_head_t           head,
    input  wire logic         pop
);

    in_item_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    logic accept;
    logic keep;

    assign busy   = (count_reg == 2'd2) || status.clearing;
    assign accept = start && !busy;
    // a cast past the screen edge gives no result and is dropped here
    assign keep   = accept &&
                    !(cmd.mode && ({1'b0, cmd.screen_column} >= 13'(SCREEN_WIDTH)));

    assign head.valid = count_reg != 2'd0;
    assign head.item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (keep)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (keep && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !keep)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            entry_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rgc_back.sv
`default_nettype none

module rgc_back
    import rgc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire q_head_t  head,
    output logic          pop,
    output back_status_t  status,
    output div_req_t      div_req,
    input  wire div_rsp_t div_rsp,
    output logic          result_valid,
    output out_item_t     result
);

    function automatic logic [MAP_BITS-1:0] clamp_cell(input logic signed [7:0] c);
        logic [MAP_BITS-1:0] r;
        if (c < 0)
        begin
            r = '0;
        end
        else if (c >= $signed(8'(MAP_DIM)))
        begin
            r = MAP_BITS'(MAP_DIM - 1);
        end
        else
        begin
            r = c[MAP_BITS-1:0];
        end
        return r;
    endfunction

    back_state_t state_reg, state_next;

    logic [ADDR_BITS-1:0] clr_cnt_reg;
    logic [11:0]          col_reg;
    logic signed [17:0]   cam_reg;
    logic signed [19:0]   rdx_reg, rdy_reg;
    logic [DELTA_W-1:0]   ddx_reg, ddy_reg;
    logic [34:0]          plo_reg;
    logic [SIDE_W-1:0]    sdx_reg, sdy_reg;
    logic signed [7:0]    mx_reg, my_reg;
    logic                 side_reg;
    logic                 left_reg;
    logic                 rd_bit_reg;
    logic [SIDE_W-1:0]    dist_reg;
    logic [15:0]          lh_reg;
    logic                 result_valid_reg;
    out_item_t            result_reg;

    logic                 mem [CELLS];
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic                 mem_wdata;
    logic [ADDR_BITS-1:0] rd_addr;

    // camera and ray
    logic [28:0]        cam_ext;
    logic signed [17:0] cam_next;
    logic signed [17:0] mul_plane;
    logic signed [17:0] mul_dir;
    logic signed [35:0] cam_prod;
    logic signed [35:0] cam_off;
    logic signed [19:0] ray_next;

    // reciprocals
    logic [19:0]        abs_x, abs_y;
    logic [DELTA_W-1:0] dd_pick;

    // initial side distances, split multiply
    logic [16:0]        frac_x, frac_y, mul_f;
    logic [17:0]        mul_d;
    logic [34:0]        side_prod;
    logic [52:0]        side_sum;
    logic [SIDE_W-1:0]  side_init;

    // walk
    logic               step_x;
    logic [SIDE_W:0]    sx_sum, sy_sum;
    logic [SIDE_W-1:0]  sdx_sat, sdy_sat;
    logic signed [7:0]  mx_step, my_step, cx, cy;
    logic               oob;

    // result
    logic [SIDE_W-1:0]  dist_calc;
    logic [DSR_W-1:0]   dist5;
    logic [15:0]        h2e;
    logic [11:0]        ds_calc;
    logic [16:0]        de_sum;
    logic [11:0]        de_calc;

    always_comb
    begin
        cam_ext  = {head.item.screen_column, 17'b0} >> SW_LOG2;
        cam_next = $signed(cam_ext[17:0]) - $signed(18'(ONE));

        mul_plane = (state_reg == ST_CAM_X) ? cfg.plane_x : cfg.plane_y;
        mul_dir   = (state_reg == ST_CAM_X) ? cfg.dir_x : cfg.dir_y;
        cam_prod  = mul_plane * cam_reg;
        cam_off   = cam_prod >>> FRAC_BITS;
        ray_next  = $signed(cam_off[19:0]) + {{2{mul_dir[17]}}, mul_dir};

        abs_x   = rdx_reg[19] ? 20'(-rdx_reg) : rdx_reg;
        abs_y   = rdy_reg[19] ? 20'(-rdy_reg) : rdy_reg;
        // a zero component takes the saturated step
        if (((state_reg == ST_DIVX_WAIT) && (rdx_reg == 0)) ||
            ((state_reg == ST_DIVY_WAIT) && (rdy_reg == 0)))
        begin
            dd_pick = DELTA_MAX;
        end
        else
        begin
            dd_pick = {3'b0, div_rsp.quot};
        end

        frac_x = rdx_reg[19] ? {1'b0, cfg.pos_x[FRAC_BITS-1:0]}
                             : 17'(ONE) - {1'b0, cfg.pos_x[FRAC_BITS-1:0]};
        frac_y = rdy_reg[19] ? {1'b0, cfg.pos_y[FRAC_BITS-1:0]}
                             : 17'(ONE) - {1'b0, cfg.pos_y[FRAC_BITS-1:0]};
        mul_f  = ((state_reg == ST_SX_LO) || (state_reg == ST_SX_HI)) ? frac_x : frac_y;
        case (state_reg)
            ST_SX_LO: mul_d = ddx_reg[17:0];
            ST_SX_HI: mul_d = ddx_reg[35:18];
            ST_SY_LO: mul_d = ddy_reg[17:0];
            default:  mul_d = ddy_reg[35:18];
        endcase
        side_prod = mul_f * mul_d;
        side_sum  = {side_prod, 18'b0} + {18'b0, plo_reg};
        side_init = SIDE_W'(side_sum >> FRAC_BITS);

        step_x  = sdx_reg < sdy_reg;
        sx_sum  = {1'b0, sdx_reg} + {9'b0, ddx_reg};
        sy_sum  = {1'b0, sdy_reg} + {9'b0, ddy_reg};
        sdx_sat = sx_sum > {1'b0, SIDE_MAX} ? SIDE_MAX : sx_sum[SIDE_W-1:0];
        sdy_sat = sy_sum > {1'b0, SIDE_MAX} ? SIDE_MAX : sy_sum[SIDE_W-1:0];
        mx_step = rdx_reg[19] ? mx_reg - 8'sd1 : mx_reg + 8'sd1;
        my_step = rdy_reg[19] ? my_reg - 8'sd1 : my_reg + 8'sd1;
        cx      = step_x ? mx_step : mx_reg;
        cy      = step_x ? my_reg : my_step;
        oob     = (cx < 0) || (cy < 0) ||
                  (cx >= $signed(8'(MAP_DIM))) || (cy >= $signed(8'(MAP_DIM)));
        rd_addr = {cy[MAP_BITS-1:0], cx[MAP_BITS-1:0]};

        dist_calc = side_reg ? (sdy_reg - {8'b0, ddy_reg}) : (sdx_reg - {8'b0, ddx_reg});
        dist5     = {3'b0, dist_reg} + {1'b0, dist_reg, 2'b0};

        h2e     = {1'b0, lh_reg[15:1]};
        ds_calc = (h2e >= 16'(SCREEN_HEIGHT / 2)) ? '0
                                                  : 12'(16'(SCREEN_HEIGHT / 2) - h2e);
        de_sum  = {1'b0, h2e} + 17'(SCREEN_HEIGHT / 2);
        de_calc = (de_sum >= 17'(SCREEN_HEIGHT)) ? 12'(SCREEN_HEIGHT - 1) : 12'(de_sum);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_BITS'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid && head.item.mode)
                begin
                    state_next = ST_CAM_X;
                end
            end
            ST_CAM_X:     state_next = ST_CAM_Y;
            ST_CAM_Y:     state_next = ST_DIVX_GO;
            ST_DIVX_GO:   state_next = ST_DIVX_WAIT;
            ST_DIVX_WAIT: state_next = div_rsp.done ? ST_DIVY_GO : ST_DIVX_WAIT;
            ST_DIVY_GO:   state_next = ST_DIVY_WAIT;
            ST_DIVY_WAIT: state_next = div_rsp.done ? ST_SX_LO : ST_DIVY_WAIT;
            ST_SX_LO:     state_next = ST_SX_HI;
            ST_SX_HI:     state_next = ST_SY_LO;
            ST_SY_LO:     state_next = ST_SY_HI;
            ST_SY_HI:     state_next = ST_WALK;
            ST_WALK:      state_next = oob ? ST_DIST : ST_CHECK;
            ST_CHECK:     state_next = rd_bit_reg ? ST_DIST : ST_WALK;
            ST_DIST:      state_next = ST_HDIV_GO;
            ST_HDIV_GO:   state_next = ST_HDIV_WAIT;
            ST_HDIV_WAIT: state_next = div_rsp.done ? ST_OUT : ST_HDIV_WAIT;
            ST_OUT:       state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop             = (state_reg == ST_IDLE) && head.valid;
        status.clearing = state_reg == ST_CLEAR;
        mem_we          = (state_reg == ST_CLEAR) ||
                          ((state_reg == ST_IDLE) && head.valid && !head.item.mode);
        mem_waddr       = (state_reg == ST_CLEAR) ? clr_cnt_reg
                                                  : {head.item.cell_row, head.item.cell_col};
        mem_wdata       = (state_reg != ST_CLEAR) && head.item.cell_is_wall;
        div_req.go      = (state_reg == ST_DIVX_GO) || (state_reg == ST_DIVY_GO) ||
                          (state_reg == ST_HDIV_GO);
        div_req.dividend = (state_reg == ST_HDIV_GO) ? HEIGHT_NUM : RECIP_NUM;
        unique case (state_reg)
            ST_DIVX_GO: div_req.divisor = DSR_W'(abs_x);
            ST_DIVY_GO: div_req.divisor = DSR_W'(abs_y);
            default:    div_req.divisor = dist5;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= state_reg == ST_OUT;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_bit_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                col_reg <= head.item.screen_column;
                cam_reg <= cam_next;
            end
            ST_CAM_X: rdx_reg <= ray_next;
            ST_CAM_Y: rdy_reg <= ray_next;
            ST_DIVX_WAIT:
            begin
                if (div_rsp.done)
                begin
                    ddx_reg <= dd_pick;
                end
            end
            ST_DIVY_WAIT:
            begin
                if (div_rsp.done)
                begin
                    ddy_reg <= dd_pick;
                end
            end
            ST_SX_LO: plo_reg <= side_prod;
            ST_SX_HI:
            begin
                sdx_reg <= side_init;
                mx_reg  <= $signed(8'(cfg.pos_x[21:FRAC_BITS]));
            end
            ST_SY_LO: plo_reg <= side_prod;
            ST_SY_HI:
            begin
                sdy_reg  <= side_init;
                my_reg   <= $signed(8'(cfg.pos_y[21:FRAC_BITS]));
                left_reg <= 1'b0;
                side_reg <= 1'b0;
            end
            ST_WALK:
            begin
                // ties step along y
                if (step_x)
                begin
                    sdx_reg  <= sdx_sat;
                    mx_reg   <= mx_step;
                    side_reg <= 1'b0;
                end
                else
                begin
                    sdy_reg  <= sdy_sat;
                    my_reg   <= my_step;
                    side_reg <= 1'b1;
                end
                left_reg <= oob;
            end
            ST_DIST: dist_reg <= dist_calc;
            ST_HDIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    lh_reg <= (|div_rsp.quot[DIV_W-1:16]) ? 16'hFFFF : div_rsp.quot[15:0];
                end
            end
            ST_OUT:
            begin
                result_reg.column_echo   <= col_reg;
                result_reg.wall_distance <= (|dist_reg[SIDE_W-1:24]) ? 24'hFF_FFFF
                                                                     : dist_reg[23:0];
                result_reg.hit_side      <= side_reg;
                result_reg.hit_cell_x    <= clamp_cell(mx_reg);
                result_reg.hit_cell_y    <= clamp_cell(my_reg);
                result_reg.slice_height  <= lh_reg;
                result_reg.draw_start    <= ds_calc;
                result_reg.draw_end      <= de_calc;
                result_reg.left_map      <= left_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

FILE: rtl/grid_ray_caster_dda_top.sv
`default_nettype none

// Grid ray caster. A beat on cmd is taken when start is high and busy is low. A map write
// (mode 0) sets one cell of the 64x64 wall grid and gives no result; a cast (mode 1) for a
// column below the screen width gives one beat on result, flagged by result_valid for a
// single cycle that the receiver must take, since it cannot stall the block. Casts are
// carried out one at a time: two reciprocal divisions and one height division (each on a
// shared one-bit-per-cycle divider), setup and output steps, plus the walk, which makes
// one grid read for every grid cell it crosses. A two entry queue takes beats while a
// cast runs. After reset a pass over all 4096 cells clears the grid, with busy held high.
// Configuration writes are taken at any time on the cfg port and must only be issued while
// no cast is outstanding.

module grid_ray_caster_dda_top
    import rgc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire in_item_t             cmd,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [21:0]          cfg_data,
    output logic                      result_valid,
    output out_item_t                 result
);

    cfg_t         cfg_reg;
    q_head_t      head;
    logic         pop;
    back_status_t status;
    div_req_t     div_req;
    div_rsp_t     div_rsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_x   <= '0;
            cfg_reg.pos_y   <= '0;
            cfg_reg.dir_x   <= 18'sd65536;
            cfg_reg.dir_y   <= '0;
            cfg_reg.plane_x <= '0;
            cfg_reg.plane_y <= 18'sd43254;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_POS_X:   cfg_reg.pos_x   <= cfg_data;
                CFG_POS_Y:   cfg_reg.pos_y   <= cfg_data;
                CFG_DIR_X:   cfg_reg.dir_x   <= $signed(cfg_data[17:0]);
                CFG_DIR_Y:   cfg_reg.dir_y   <= $signed(cfg_data[17:0]);
                CFG_PLANE_X: cfg_reg.plane_x <= $signed(cfg_data[17:0]);
                CFG_PLANE_Y: cfg_reg.plane_y <= $signed(cfg_data[17:0]);
                default:
                begin
                end
            endcase
        end
    end

    rgc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .status (status),
        .head   (head),
        .pop    (pop)
    );

    rgc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rgc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .pop          (pop),
        .status       (status),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire
